// ----- sv/ffa_pkg.sv -----
package ffa_pkg;

    // Arena geometry and free list depth
    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_FREE     = 64;
    localparam int ADDR_W       = 16;
    localparam int REC_DEPTH    = 1 << ADDR_W;

    localparam logic [ADDR_W-1:0] HDR_LEN   = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(ARENA_BYTES - HEADER_BYTES);

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic [1:0]        status;
    } t_rsp;

    // One free list entry
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] size;
    } t_entry;

    // Broadcast command to every cell of the free list
    typedef struct packed {
        logic              cmp;
        logic              split;
        logic              remove;
        logic              push;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] new_offset;
        logic [ADDR_W-1:0] rem_size;
    } t_cell_cmd;

endpackage

// ----- sv/ffa_ram.sv -----
module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one word, registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ffa_cell.sv -----
module ffa_cell
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_rst_entry,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  logic      i_sel,
    input  logic      i_ge,
    output t_entry    o_entry,
    output logic      o_fit
);

    t_entry r_entry;
    logic   r_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_rst_entry;
            r_fit   <= 1'b0;
        end else begin
            // Flag whether this entry holds the request
            if (i_cmd.cmp) begin
                r_fit <= r_entry.valid && (r_entry.size >= i_cmd.req);
            end
            // Shift down on push, shift up on removal, shrink on split
            if (i_cmd.push) begin
                r_entry <= i_prev;
            end else if (i_cmd.remove && i_ge) begin
                r_entry <= i_next;
            end else if (i_cmd.split && i_sel) begin
                r_entry.offset <= i_cmd.new_offset;
                r_entry.size   <= i_cmd.rem_size;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_fit   = r_fit;

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// First-fit block allocator over a 64 KiB arena with a 16-byte header per block.
// Request channel: i_req_valid / o_req_stall carry opcode, request_size and
// block_address. Response channel: o_rsp_valid / i_rsp_stall carry the payload
// offset and a status code. Every request yields exactly one response.
// The free list lives in a row of 64 cells; each cell compares its own size
// against the request, a one-hot pick selects the first fit, and the cells
// shift up on a removal or down on a free push.
// A request passes through S_CMP, S_SEL, S_PICK, S_UPD and S_DONE before
// its result is loaded into the response register; an allocate that splits
// a block also passes through S_WR2, because both size records go through
// the single port of the size-record memory. One request is in flight at a
// time; the stall output is high while a request is being worked on.
// A finished response waits in the output register while i_rsp_stall is high;
// the next request is accepted meanwhile, and its own result waits until the
// register is free.
// Reset (synchronous, active low) leaves one free entry spanning the whole
// arena and an empty output register. The size records are not cleared.
module first_fit_block_allocator
    import ffa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int REC_AW = $clog2(REC_DEPTH);

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    t_req                r_req;
    logic [ADDR_W-1:0]   r_hdr;
    logic [ADDR_W-1:0]   r_bsize;
    logic                r_rec0_wr;
    logic [MAX_FREE-1:0] r_first;
    logic [MAX_FREE-1:0] r_ge;
    logic                r_any;
    logic [ADDR_W-1:0]   r_pick_off;
    logic [ADDR_W-1:0]   r_pick_size;
    logic [ADDR_W-1:0]   r_noff;
    logic [ADDR_W-1:0]   r_nsz;
    logic                r_split;
    logic                r_ok;
    t_rsp                r_result;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    t_entry              w_entry [MAX_FREE];
    logic [MAX_FREE-1:0] w_fit;
    logic [MAX_FREE-1:0] w_fm1;
    t_entry              w_pick;
    t_entry              w_push;
    t_cell_cmd           w_cmd;
    logic                w_is_alloc;
    logic                w_out_free;
    logic [16:0]         w_need;
    logic                w_ram_en;
    logic                w_ram_we;
    logic [REC_AW-1:0]   w_ram_addr;
    logic [ADDR_W-1:0]   w_ram_wdata;
    logic [ADDR_W-1:0]   w_ram_rdata;

    assign w_is_alloc = (r_req.opcode == OP_ALLOC);
    assign w_out_free = !r_rsp_valid || !i_rsp_stall;

    // Row of free list cells
    for (genvar g = 0; g < MAX_FREE; g++) begin : g_cell
        t_entry w_rst;
        t_entry w_prev;
        t_entry w_next;

        assign w_rst  = (g == 0) ? t_entry'{valid: 1'b1, offset: '0, size: INIT_SIZE}
                                 : t_entry'('0);
        assign w_prev = (g == 0) ? w_push : w_entry[(g == 0) ? 0 : g - 1];
        assign w_next = (g == MAX_FREE - 1) ? '0
                                            : w_entry[(g == MAX_FREE - 1) ? g : g + 1];

        ffa_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_rst_entry (w_rst),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_sel       (r_first[g]),
            .i_ge        (r_ge[g]),
            .o_entry     (w_entry[g]),
            .o_fit       (w_fit[g])
        );
    end

    // Entry pushed at the list front by a free
    assign w_push = '{valid: 1'b1, offset: r_hdr, size: r_bsize};

    // Lowest set fit bit by borrow propagation
    assign w_fm1 = w_fit - MAX_FREE'(1);

    // Gather the selected entry
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < MAX_FREE; i++) begin
            w_pick = w_pick | (r_first[i] ? w_entry[i] : '0);
        end
    end

    assign w_need = {1'b0, r_req.request_size} + {1'b0, HDR_LEN};

    // Broadcast command to the cells
    always_comb begin
        w_cmd            = '0;
        w_cmd.cmp        = (r_state == S_CMP);
        w_cmd.req        = r_req.request_size;
        w_cmd.new_offset = r_noff;
        w_cmd.rem_size   = r_nsz;
        if (r_state == S_UPD && r_ok) begin
            w_cmd.split  = w_is_alloc && r_split;
            w_cmd.remove = w_is_alloc && !r_split;
            w_cmd.push   = !w_is_alloc;
        end
    end

    // Size record memory port
    always_comb begin
        w_ram_en    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_hdr;
        w_ram_wdata = r_pick_size;
        unique case (r_state)
            S_CMP: begin
                w_ram_en = !w_is_alloc;
            end
            S_UPD: begin
                w_ram_en = r_ok && w_is_alloc;
                w_ram_we = r_ok && w_is_alloc;
                if (r_split) begin
                    w_ram_addr  = r_noff;
                    w_ram_wdata = r_nsz;
                end else begin
                    w_ram_addr  = r_pick_off;
                    w_ram_wdata = r_pick_size;
                end
            end
            S_WR2: begin
                w_ram_en    = 1'b1;
                w_ram_we    = 1'b1;
                w_ram_addr  = r_pick_off;
                w_ram_wdata = r_req.request_size;
            end
            default: begin
                w_ram_en = 1'b0;
            end
        endcase
    end

    ffa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (REC_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_CMP;
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = S_PICK;
            S_PICK: n_state = S_UPD;
            S_UPD:  n_state = (r_ok && w_is_alloc && r_split) ? S_WR2 : S_DONE;
            S_WR2:  n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rec0_wr   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Note the first write of the record at offset zero
            if (w_ram_en && w_ram_we && w_ram_addr == '0) begin
                r_rec0_wr <= 1'b1;
            end
            // Load a finished response, drop a taken one
            if (r_state == S_DONE && w_out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req <= i_req;
            r_hdr <= i_req.block_address - HDR_LEN;
        end
        if (r_state == S_SEL) begin
            r_first <= w_fit & ~w_fm1;
            r_ge    <= ~(w_fit ^ w_fm1) | (w_fit & ~w_fm1);
            r_any   <= |w_fit;
            r_bsize <= (r_hdr == '0 && !r_rec0_wr) ? INIT_SIZE : w_ram_rdata;
        end
        if (r_state == S_PICK) begin
            r_pick_off  <= w_pick.offset;
            r_pick_size <= w_pick.size;
            r_split     <= {1'b0, w_pick.size} > w_need;
            r_noff      <= w_pick.offset + HDR_LEN + r_req.request_size;
            r_nsz       <= w_pick.size - r_req.request_size - HDR_LEN;
            if (w_is_alloc) begin
                r_ok <= (r_req.request_size != '0) && r_any;
                if ((r_req.request_size != '0) && r_any) begin
                    r_result <= '{payload_address: w_pick.offset + HDR_LEN, status: ST_OK};
                end else begin
                    r_result <= '{payload_address: '0, status: ST_FAIL};
                end
            end else begin
                r_result.payload_address <= '0;
                priority if (r_req.block_address == '0) begin
                    r_ok            <= 1'b0;
                    r_result.status <= ST_NULL;
                end else if (w_entry[MAX_FREE-1].valid) begin
                    r_ok            <= 1'b0;
                    r_result.status <= ST_FULL;
                end else begin
                    r_ok            <= 1'b1;
                    r_result.status <= ST_OK;
                end
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_rsp <= r_result;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- tb/sv/tb_first_fit_block_allocator.sv -----
import ffa_pkg::*;

// Shadow of the allocator: free list, size records and the responses still owed
class heap_model;
    logic [ADDR_W-1:0] list_offset [MAX_FREE];
    logic [ADDR_W-1:0] list_size   [MAX_FREE];
    int                list_count;
    logic [ADDR_W-1:0] size_record [int];
    logic [ADDR_W-1:0] recorded_hdrs [$];
    logic [ADDR_W-1:0] live_blocks [$];
    t_rsp              expected_rsp [$];
    int                errors;

    function new();
        foreach (list_offset[k]) begin
            list_offset[k] = '0;
            list_size[k]   = '0;
        end
        list_size[0] = INIT_SIZE;
        list_count   = 1;
        errors       = 0;
        write_record('0, INIT_SIZE);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Remember which header offsets hold a size, so frees never read an empty one
    function void write_record(logic [ADDR_W-1:0] hdr, logic [ADDR_W-1:0] sz);
        if (!size_record.exists(int'(hdr)))
            recorded_hdrs.push_back(hdr);
        size_record[int'(hdr)] = sz;
    endfunction

    // Take the first entry large enough; split it when the tail holds more than a header
    function t_rsp alloc_first_fit(logic [ADDR_W-1:0] want);
        t_rsp              res;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] rem_off;
        logic [ADDR_W-1:0] rem_size;
        res.payload_address = '0;
        res.status          = ST_FAIL;
        if (want == '0)
            return res;
        for (int i = 0; i < list_count; i++) begin
            if (list_size[i] >= want) begin
                base = list_offset[i];
                if (int'(list_size[i]) > int'(want) + HEADER_BYTES) begin
                    rem_off        = base + HDR_LEN + want;
                    rem_size       = list_size[i] - want - HDR_LEN;
                    list_offset[i] = rem_off;
                    list_size[i]   = rem_size;
                    write_record(rem_off, rem_size);
                    write_record(base, want);
                end else begin
                    write_record(base, list_size[i]);
                    for (int k = i; k + 1 < list_count; k++) begin
                        list_offset[k] = list_offset[k+1];
                        list_size[k]   = list_size[k+1];
                    end
                    list_count--;
                end
                res.payload_address = base + HDR_LEN;
                res.status          = ST_OK;
                live_blocks.push_back(res.payload_address);
                return res;
            end
        end
        return res;
    endfunction

    // Push the block at the list front with its recorded size; a null address or a full list fails
    function t_rsp free_block(logic [ADDR_W-1:0] addr);
        t_rsp              res;
        logic [ADDR_W-1:0] hdr;
        res.payload_address = '0;
        if (addr == '0) begin
            res.status = ST_NULL;
            return res;
        end
        if (list_count >= MAX_FREE) begin
            res.status = ST_FULL;
            return res;
        end
        hdr = addr - HDR_LEN;
        for (int k = list_count; k > 0; k--) begin
            list_offset[k] = list_offset[k-1];
            list_size[k]   = list_size[k-1];
        end
        list_offset[0] = hdr;
        list_size[0]   = size_record[int'(hdr)];
        list_count++;
        foreach (live_blocks[k]) begin
            if (live_blocks[k] == addr) begin
                live_blocks.delete(k);
                break;
            end
        end
        res.status = ST_OK;
        return res;
    endfunction

    function void note_request(t_req r);
        if (r.opcode == OP_ALLOC)
            expected_rsp.push_back(alloc_first_fit(r.request_size));
        else
            expected_rsp.push_back(free_block(r.block_address));
    endfunction

    task check_response(t_rsp got);
        t_rsp want;
        if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with none pending: addr=%h status=%0d",
                                      got.payload_address, got.status));
            return;
        end
        want = expected_rsp.pop_front();
        if (got.payload_address !== want.payload_address)
            report_mismatch($sformatf("payload_address got %h want %h",
                                      got.payload_address, want.payload_address));
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
endclass

module tb_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 950;
    localparam int CALM_ITEMS  = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp;

    heap_model heap;
    bit        idle_on = 1'b1;
    int        sent    = 0;

    first_fit_block_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Present one request, hold it until accepted, then note it
    task automatic send_request(t_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        heap.note_request(r);
        sent++;
    endtask

    task automatic send_alloc(logic [ADDR_W-1:0] size);
        t_req r;
        r.opcode        = OP_ALLOC;
        r.request_size  = size;
        r.block_address = ADDR_W'($urandom);
        send_request(r);
    endtask

    task automatic send_free(logic [ADDR_W-1:0] addr);
        t_req r;
        r.opcode        = OP_FREE;
        r.request_size  = ADDR_W'($urandom);
        r.block_address = addr;
        send_request(r);
    endtask

    // Allocate a run of small blocks, then release every live block in random order
    task automatic churn_blocks(int count);
        logic [ADDR_W-1:0] pool [$];
        int                idx;
        repeat (count) send_alloc(ADDR_W'($urandom_range(1, 48)));
        pool = heap.live_blocks;
        while (pool.size() != 0) begin
            idx = $urandom_range(0, pool.size() - 1);
            send_free(pool[idx]);
            pool.delete(idx);
        end
    endtask

    // Pick one random request from the current heap state
    function automatic t_req make_request();
        t_req r;
        int   free_pct;
        int   pick;
        int   e;
        int   d;
        r.request_size  = ADDR_W'($urandom);
        r.block_address = ADDR_W'($urandom);
        free_pct = (heap.live_blocks.size() == 0) ? 10 :
                   (heap.live_blocks.size() > 40) ? 70 : 40;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < free_pct) begin
            r.opcode = OP_FREE;
            if (pick < 8) begin
                r.block_address = '0;
            end else if (pick < 20 || heap.live_blocks.size() == 0) begin
                // foreign or repeated free of any block that has a size record
                if (heap.recorded_hdrs.size() == 0)
                    r.block_address = '0;
                else
                    r.block_address = heap.recorded_hdrs[
                        $urandom_range(0, heap.recorded_hdrs.size() - 1)] + HDR_LEN;
            end else begin
                r.block_address = heap.live_blocks[
                    $urandom_range(0, heap.live_blocks.size() - 1)];
            end
        end else begin
            r.opcode = OP_ALLOC;
            if (pick < 4) begin
                r.request_size = '0;
            end else if (pick < 8) begin
                r.request_size = ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
            end else if (pick < 30 && heap.list_count > 0) begin
                // size close to an entry, around the split threshold
                e = $urandom_range(0, heap.list_count - 1);
                d = $urandom_range(0, HEADER_BYTES + 1);
                r.request_size = (int'(heap.list_size[e]) > d) ?
                                 heap.list_size[e] - ADDR_W'(d) : heap.list_size[e];
            end else if (pick < 80) begin
                r.request_size = ADDR_W'($urandom_range(1, 64));
            end else begin
                r.request_size = ADDR_W'($urandom_range(65, 4096));
            end
        end
        return r;
    endfunction

    // Accept responses and stall in random bursts
    initial begin : rsp_side
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                heap.check_response(rsp);
            if (hold > 0)
                hold--;
            else if (idle_on && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 5);
            rsp_stall <= (hold > 0);
        end
    end

    initial begin : stimulus
        heap = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: failures, whole-arena take, empty list, split boundaries
        send_alloc('0);
        send_alloc(16'hFFFF);
        send_free('0);
        send_alloc(INIT_SIZE);
        send_alloc(16'd1);
        send_free(HDR_LEN);
        send_alloc(16'd1);
        send_alloc(16'd2);
        send_free(16'd33);
        send_alloc(16'd2);
        send_free(16'd33);
        send_alloc(16'd1);
        send_alloc(16'h7FF0);
        send_alloc(16'h7FFF);
        send_free(16'd51);
        send_alloc(16'h7FF0 - HDR_LEN);
        send_free(16'd51);
        send_alloc(16'h7FF0 - HDR_LEN - 16'd1);
        send_alloc(16'd32700);
        send_free(16'd16);
        send_free(16'd16);

        // Random mix with occasional allocate/free churn; calm at the end
        while (sent < TOTAL_ITEMS) begin
            if (sent >= TOTAL_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if ($urandom_range(0, 11) == 0)
                churn_blocks($urandom_range(20, 70));
            else
                send_request(make_request());
        end
        idle_on = 1'b0;
        req_valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (heap.expected_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (heap.errors == 0)
            $display("** first_fit_block_allocator: PASSED **");
        else
            $display("** first_fit_block_allocator: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("** first_fit_block_allocator: FAILED **");
        $finish;
    end
endmodule
